// File: rtl/ifd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ifd_pkg;

    // character codes seen on the serial line
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int unsigned LEN_W = 10;
    localparam logic [LEN_W-1:0] LEN_MAX = 10'd1023;

    // one result beat
    typedef struct packed {
        logic [7:0]       payload_byte;
        logic             payload_valid;
        logic             payload_last;
        logic             frame_done;
        logic [LEN_W-1:0] declared_length;
        logic             frame_short;
    } result_t;

    // expected header letter at a given position
    function automatic logic [7:0] hdr_letter(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = CH_I;
            2'd1:    ch = CH_P;
            default: ch = CH_D;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ipd_frame_deframer.sv
// ipd_frame_deframer: streaming parser for +IPD,id,len:payload<CR> frames
// result: each beat is registered into the output register, or into the skid slot if the output register is stalled
// throughput: one byte per cycle while in_ready is high; the state step is a single registered pass
// output register plus skid slot; input stalls only while both hold a beat
// reset: rst_n asynchronous, active low; parser returns to idle, output stage empties
`timescale 1ns / 1ps
`default_nettype none

module ipd_frame_deframer
    import ifd_pkg::*;
#(
    parameter int MAX_LENGTH_DIGITS = 3
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic       rx_error,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      payload_byte,
    output logic            payload_valid,
    output logic            payload_last,
    output logic            frame_done,
    output logic [9:0]      declared_length,
    output logic            frame_short
);

    result_t res;
    result_t out_data;
    logic    res_valid;
    logic    in_fire;

    assign in_fire = in_valid && in_ready;

    // frame state step
    ifd_parser #(
        .MAX_LENGTH_DIGITS(MAX_LENGTH_DIGITS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .rx_byte  (rx_byte),
        .rx_error (rx_error),
        .res      (res),
        .res_valid(res_valid)
    );

    // result register and skid slot
    ifd_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_data(res),
        .push     (res_valid),
        .in_ready (in_ready),
        .out_data (out_data),
        .out_valid(out_valid),
        .out_ready(out_ready)
    );

    assign payload_byte    = out_data.payload_byte;
    assign payload_valid   = out_data.payload_valid;
    assign payload_last    = out_data.payload_last;
    assign frame_done      = out_data.frame_done;
    assign declared_length = out_data.declared_length;
    assign frame_short     = out_data.frame_short;

endmodule

`default_nettype wire

// File: rtl/ifd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module ifd_parser
    import ifd_pkg::*;
#(
    parameter int MAX_LENGTH_DIGITS = 3
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_fire,
    input  wire logic [7:0] rx_byte,
    input  wire logic    rx_error,
    output result_t      res,
    output logic         res_valid
);

    localparam int DCW = $clog2(MAX_LENGTH_DIGITS + 1);
    localparam logic [DCW-1:0] DIGIT_LIMIT = DCW'(MAX_LENGTH_DIGITS);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_HDR  = 3'd1;
    localparam logic [2:0] PH_PRE  = 3'd2;
    localparam logic [2:0] PH_ID   = 3'd3;
    localparam logic [2:0] PH_LEN  = 3'd4;
    localparam logic [2:0] PH_PAY  = 3'd5;
    localparam logic [2:0] PH_TAIL = 3'd6;

    logic [2:0]       phase_reg, phase_next;
    logic [1:0]       hdr_cnt_reg, hdr_cnt_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [DCW-1:0]   dig_cnt_reg, dig_cnt_next;
    logic [LEN_W-1:0] pay_cnt_reg, pay_cnt_next;

    // length accumulate with saturation: len*10 + digit
    logic [13:0] len_mac;
    logic        is_digit;
    logic [LEN_W-1:0] pay_cnt_inc;
    logic        reach_len;

    assign is_digit    = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign len_mac     = ({4'd0, len_reg} << 3) + ({4'd0, len_reg} << 1)
                         + {10'd0, rx_byte[3:0]};
    assign pay_cnt_inc = pay_cnt_reg + 10'd1;
    assign reach_len   = (pay_cnt_inc >= len_reg);

    // per-byte state step and result
    always_comb
    begin
        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        len_next     = len_reg;
        dig_cnt_next = dig_cnt_reg;
        pay_cnt_next = pay_cnt_reg;
        res          = '0;
        res_valid    = 1'b0;

        if (in_fire && !rx_error) begin
            if (rx_byte == CH_PLUS) begin
                phase_next   = PH_HDR;
                hdr_cnt_next = '0;
                len_next     = '0;
                dig_cnt_next = '0;
                pay_cnt_next = '0;
            end else if (phase_reg != PH_IDLE) begin
                if (rx_byte == CH_CR) begin
                    res_valid           = 1'b1;
                    res.frame_done      = 1'b1;
                    res.declared_length = len_reg;
                    res.frame_short     = (pay_cnt_reg < len_reg);
                    phase_next          = PH_IDLE;
                    hdr_cnt_next        = '0;
                    len_next            = '0;
                    dig_cnt_next        = '0;
                    pay_cnt_next        = '0;
                end else begin
                    unique case (phase_reg)
                        PH_HDR:
                        begin
                            if (hdr_cnt_reg != 2'd3 && rx_byte == hdr_letter(hdr_cnt_reg)) begin
                                hdr_cnt_next = hdr_cnt_reg + 2'd1;
                                if (hdr_cnt_reg == 2'd2) begin
                                    phase_next = PH_PRE;
                                end
                            end else begin
                                phase_next   = PH_IDLE;
                                hdr_cnt_next = '0;
                                len_next     = '0;
                                dig_cnt_next = '0;
                                pay_cnt_next = '0;
                            end
                        end
                        PH_PRE:
                        begin
                            if (rx_byte == CH_COMMA) begin
                                phase_next = PH_ID;
                            end
                        end
                        PH_ID:
                        begin
                            if (rx_byte == CH_COMMA) begin
                                phase_next = PH_LEN;
                            end
                        end
                        PH_LEN:
                        begin
                            if (is_digit) begin
                                if (dig_cnt_reg < DIGIT_LIMIT) begin
                                    len_next = (len_mac > {4'd0, LEN_MAX}) ? LEN_MAX
                                                                            : len_mac[LEN_W-1:0];
                                    dig_cnt_next = dig_cnt_reg + DCW'(1);
                                end
                            end else if (rx_byte == CH_COLON) begin
                                phase_next = (len_reg == '0) ? PH_TAIL : PH_PAY;
                            end
                        end
                        PH_PAY:
                        begin
                            pay_cnt_next        = pay_cnt_inc;
                            res_valid           = 1'b1;
                            res.payload_byte    = rx_byte;
                            res.payload_valid   = 1'b1;
                            res.payload_last    = reach_len;
                            res.declared_length = len_reg;
                            if (reach_len) begin
                                phase_next = PH_TAIL;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= PH_IDLE;
            hdr_cnt_reg <= '0;
            len_reg     <= '0;
            dig_cnt_reg <= '0;
            pay_cnt_reg <= '0;
        end else begin
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            len_reg     <= len_next;
            dig_cnt_reg <= dig_cnt_next;
            pay_cnt_reg <= pay_cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ifd_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module ifd_out_stage
    import ifd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire result_t push_data,
    input  wire logic    push,
    output logic         in_ready,
    output result_t      out_data,
    output logic         out_valid,
    input  wire logic    out_ready
);

    result_t out_reg;
    logic    out_valid_reg;
    result_t skid_reg;
    logic    skid_valid_reg;
    logic    pop;

    assign pop       = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

    // valid flags of the output register and skid slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_reg <= push_data;
            end else begin
                out_reg <= push_data;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/ifd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ifd_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [7:0] rx_byte,
    input wire logic       rx_error,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] payload_byte,
    input wire logic       payload_valid,
    input wire logic       payload_last,
    input wire logic       frame_done,
    input wire logic [9:0] declared_length,
    input wire logic       frame_short
);

    // a waiting input beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(rx_byte) && $stable(rx_error))
        else $error("input beat changed while waiting");

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(payload_byte)
            && $stable(frame_done) && $stable(declared_length))
        else $error("result beat changed while stalled");

    // every beat is either a payload byte or a frame end, never both
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (payload_valid != frame_done))
        else $error("beat kind is not exactly one of payload or frame end");

    // last marker and short flag belong to their own beat kind
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (payload_last || (payload_byte != 8'd0)) |-> payload_valid)
        else $error("payload fields set on a frame end beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_short |-> frame_done && (declared_length != 10'd0))
        else $error("short flag without a frame end or declared length");

endmodule

bind ipd_frame_deframer ifd_checker u_ifd_checker (.*);

`default_nettype wire
